[design/bap_pkg.sv]
// Shared constants and types for the block average pixelate design.
package bap_pkg;

  localparam int unsigned MaxWidth  = 2048;
  localparam int unsigned MaxHeight = 4096;
  localparam int unsigned MaxBlock  = 64;

  localparam int unsigned ColW   = $clog2(MaxWidth);   // 11
  localparam int unsigned RowW   = $clog2(MaxHeight);  // 12
  localparam int unsigned InTileW = $clog2(MaxBlock);  // 6
  localparam int unsigned SumW   = 20;
  localparam int unsigned CntW   = 2 * (InTileW + 1);  // 14, holds 64*64
  localparam int unsigned QuoW   = SumW;
  localparam int unsigned DivSteps = SumW;

  localparam logic [1:0] RegWidth  = 2'd0;
  localparam logic [1:0] RegHeight = 2'd1;
  localparam logic [1:0] RegBlock  = 2'd2;

  // Commands from controller to datapath
  typedef struct packed {
    logic acc_en;     // accumulate the accepted pixel
    logic div_start;  // begin division of the finished tile
    logic div_step;   // run one restoring division step
    logic out_load;   // move quotients to the output register
  } bap_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic tile_end;   // accepted pixel finishes a tile
    logic div_last;   // current step is the last one
  } bap_sts_t;

endpackage

[design/bap_ctrl.sv]
// Controller: sequences accumulation, division and output handoff.
module bap_ctrl
  import bap_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  logic     out_busy_i,
  input  bap_sts_t sts_i,
  output bap_cmd_t cmd_o
);

  typedef enum logic [1:0] {StIdle, StDiv, StWait} state_e;
  state_e state_q, state_d;

  assign in_ready_o = (state_q == StIdle);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          cmd_o.acc_en = 1'b1;
          if (sts_i.tile_end) begin
            cmd_o.div_start = 1'b1;
            state_d = StDiv;
          end
        end
      end
      StDiv: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_last) state_d = StWait;
      end
      StWait: begin
        if (!out_busy_i) begin
          cmd_o.out_load = 1'b1;
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  // Hold state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

[design/bap_dpath.sv]
// Datapath: raster counters, per-column sum memory, tile divider, output register.
module bap_dpath
  import bap_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [11:0]         width_i,
  input  logic [12:0]         height_i,
  input  logic [6:0]          block_i,
  input  logic                restart_i,
  input  logic [23:0]         pix_i,
  input  bap_cmd_t            cmd_i,
  output bap_sts_t            sts_o,
  input  logic                out_take_i,
  output logic                out_valid_o,
  output logic [47:0]         out_data_o
);

  // Clamp configuration
  logic [ColW:0]     w_c;
  logic [RowW:0]     h_c;
  logic [InTileW:0]  b_c;
  always_comb begin
    w_c = (width_i == '0) ? (ColW+1)'(1) :
          ({1'b0, width_i} > 13'(MaxWidth)) ? (ColW+1)'(MaxWidth) : (ColW+1)'(width_i);
    h_c = (height_i == '0) ? (RowW+1)'(1) :
          ({1'b0, height_i} > 14'(MaxHeight)) ? (RowW+1)'(MaxHeight) : (RowW+1)'(height_i);
    b_c = (block_i == '0) ? (InTileW+1)'(1) :
          (block_i > 7'(MaxBlock)) ? (InTileW+1)'(MaxBlock) : (InTileW+1)'(block_i);
  end

  // Raster position
  logic [ColW-1:0]    pcol_q;
  logic [RowW-1:0]    prow_q;
  logic [InTileW-1:0] cit_q, rit_q;
  logic [ColW-1:0]    tidx_q;
  logic [RowW-1:0]    trow_q;

  logic last_col, last_row, col_end, row_end;
  assign last_col = ({1'b0, pcol_q} + 1'b1) >= w_c;
  assign last_row = ({1'b0, prow_q} + 1'b1) >= h_c;
  assign col_end  = ({1'b0, cit_q} + 1'b1) >= b_c;
  assign row_end  = ({1'b0, rit_q} + 1'b1) >= b_c;
  assign sts_o.tile_end = (last_col || col_end) && (last_row || row_end);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pcol_q <= '0; prow_q <= '0; cit_q <= '0; rit_q <= '0;
      tidx_q <= '0; trow_q <= '0;
    end else if (restart_i) begin
      pcol_q <= '0; prow_q <= '0; cit_q <= '0; rit_q <= '0;
      tidx_q <= '0; trow_q <= '0;
    end else if (cmd_i.acc_en) begin
      if (last_col) begin
        pcol_q <= '0; cit_q <= '0; tidx_q <= '0;
        if (last_row) begin
          prow_q <= '0; rit_q <= '0; trow_q <= '0;
        end else begin
          prow_q <= prow_q + 1'b1;
          if (row_end) begin
            rit_q  <= '0;
            trow_q <= trow_q + 1'b1;
          end else begin
            rit_q <= rit_q + 1'b1;
          end
        end
      end else begin
        pcol_q <= pcol_q + 1'b1;
        if (col_end) begin
          cit_q  <= '0;
          tidx_q <= tidx_q + 1'b1;
        end else begin
          cit_q <= cit_q + 1'b1;
        end
      end
    end
  end

  // Sum memory: read old entry combinationally is not allowed, so keep a
  // running sum register for the current tile column in the row and use
  // the memory only for the value carried between rows. When the entry
  // read back was written at the same edge, take the running sum instead.
  logic [3*SumW-1:0] mem [MaxWidth];
  logic [3*SumW-1:0] rd_q;
  logic              rd_hit_q;
  logic [3*SumW-1:0] cur_q;

  // Pre-read next column's entry: issue read for tile index the next pixel uses
  logic [ColW-1:0] next_tidx;
  always_comb begin
    next_tidx = tidx_q;
    if (restart_i) next_tidx = '0;
    else if (cmd_i.acc_en) begin
      if (last_col) next_tidx = '0;
      else if (col_end) next_tidx = tidx_q + 1'b1;
    end
  end

  logic first_pix;
  assign first_pix = (cit_q == '0) && (rit_q == '0);

  // Running sum for the active tile column
  logic [3*SumW-1:0] base, acc_sum;
  always_comb begin
    base = first_pix ? '0 : (cit_q == '0 ? (rd_hit_q ? cur_q : rd_q) : cur_q);
    acc_sum = {base[3*SumW-1:2*SumW] + SumW'(pix_i[23:16]),
               base[2*SumW-1:SumW]   + SumW'(pix_i[15:8]),
               base[SumW-1:0]        + SumW'(pix_i[7:0])};
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.acc_en) begin
      cur_q <= acc_sum;
      mem[tidx_q] <= acc_sum;
    end
    rd_q     <= mem[next_tidx];
    rd_hit_q <= cmd_i.acc_en && (next_tidx == tidx_q);
  end

  // Tile size
  logic [ColW:0]    x0;
  logic [RowW:0]    y0;
  logic [ColW:0]    wrem;
  logic [RowW:0]    hrem;
  logic [InTileW:0] tw, th;
  always_comb begin
    x0 = {1'b0, pcol_q} - (ColW+1)'(cit_q);
    y0 = {1'b0, prow_q} - (RowW+1)'(rit_q);
    wrem = w_c - x0;
    hrem = h_c - y0;
    tw = (wrem < (ColW+1)'(b_c)) ? wrem[InTileW:0] : b_c;
    th = (hrem < (RowW+1)'(b_c)) ? hrem[InTileW:0] : b_c;
  end

  // Restoring divider, three channels sharing one divisor and step counter
  logic [CntW-1:0]   div_q;
  logic [3*SumW-1:0] quo_q;
  logic [3*CntW-1:0] rem_q;
  logic [4:0]        step_q;
  logic [ColW-1:0]   ocol_q;
  logic [RowW-1:0]   orow_q;
  logic              odone_q;

  assign sts_o.div_last = (step_q == 5'(DivSteps - 1));

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_start) begin
      div_q   <= CntW'(tw) * CntW'(th);
      quo_q   <= acc_sum;
      rem_q   <= '0;
      step_q  <= '0;
      ocol_q  <= tidx_q;
      orow_q  <= trow_q;
      odone_q <= last_col && last_row;
    end else if (cmd_i.div_step) begin
      for (int c = 0; c < 3; c++) begin
        logic [CntW:0] sh;
        logic [CntW:0] df;
        sh = {rem_q[c*CntW +: CntW], quo_q[c*SumW + SumW - 1]};
        df = sh - {1'b0, div_q};
        if (!df[CntW]) begin
          rem_q[c*CntW +: CntW] <= df[CntW-1:0];
          quo_q[c*SumW +: SumW] <= {quo_q[c*SumW +: SumW-1], 1'b1};
        end else begin
          rem_q[c*CntW +: CntW] <= sh[CntW-1:0];
          quo_q[c*SumW +: SumW] <= {quo_q[c*SumW +: SumW-1], 1'b0};
        end
      end
      step_q <= step_q + 1'b1;
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_o <= 1'b1;
    end else if (out_take_i) begin
      out_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_data_o <= {odone_q, orow_q, ocol_q,
                     quo_q[2*SumW +: 8], quo_q[SumW +: 8], quo_q[7:0]};
    end
  end

endmodule

[design/block_average_pixelate_top.sv]
// Top level of the block average pixelate tile averager.
// Usage:
//  - Slave stream s_axis_*: one RGB pixel per transfer in raster order,
//    tdata = {blue, green, red}, red in the lowest byte.
//  - Master stream m_axis_*: one transfer per finished tile carrying the
//    truncated mean color, tile column, tile row and frame_done.
//  - APB port: image width at 0x0, image height at 0x4, tile edge at 0x8.
//    A write to one of these registers restarts the frame at pixel (0,0).
// Pixels that do not end a tile are accepted back to back. A pixel that
// ends a tile is accumulated, then the bit-serial divider runs (one
// quotient bit per cycle), then, after any wait for the output register
// to free up, the quotients are loaded into it.
// Reset clears the raster position and registers to 640, 480 and 8.
// The sum memory is not cleared: each tile's first pixel writes its entry.
// While the receiver stalls, the finished result holds in the output
// register and further pixels are taken until the next tile ends.
module block_average_pixelate_top
  import bap_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // red, green, blue
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // avg_red, avg_green, avg_blue, tile_col, tile_row, frame_done
  output logic [47:0] m_axis_tdata,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [11:0] width_q;
  logic [12:0] height_q;
  logic [6:0]  block_q;
  logic        wr_en, restart;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign restart = wr_en && (paddr[3:2] inside {RegWidth, RegHeight, RegBlock}) &&
                   (paddr[1:0] == 2'b00);

  // Register file
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q <= 12'd640; height_q <= 13'd480; block_q <= 7'd8;
    end else if (restart) begin
      case (paddr[3:2])
        RegWidth:  width_q  <= pwdata[11:0];
        RegHeight: height_q <= pwdata[12:0];
        RegBlock:  block_q  <= pwdata[6:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      RegWidth:  prdata = 32'(width_q);
      RegHeight: prdata = 32'(height_q);
      RegBlock:  prdata = 32'(block_q);
      default:   prdata = '0;
    endcase
  end

  bap_cmd_t cmd;
  bap_sts_t sts;
  logic     in_ready;

  bap_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (in_ready),
    .out_busy_i (m_axis_tvalid && !m_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );
  assign s_axis_tready = in_ready;

  bap_dpath u_dpath (
    .clk_i, .rst_ni,
    .width_i     (width_q),
    .height_i    (height_q),
    .block_i     (block_q),
    .restart_i   (restart),
    .pix_i       (s_axis_tdata),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_take_i  (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_data_o  (m_axis_tdata)
  );

endmodule

[design/bap_checker.sv]
// Port-level checker for the block average pixelate top level.
module bap_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [47:0] m_axis_tdata,
  input logic        pready
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result dropped under stall");

  a_hs_known: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$isunknown({s_axis_tready, m_axis_tvalid}))
    else $error("handshake output unknown");

  a_pready: assert property (@(posedge clk_i) disable iff (!rst_ni) pready)
    else $error("pready low");

endmodule

bind block_average_pixelate_top bap_checker u_bap_checker (.*);

[sim/tb_top.sv]
// Self-checking testbench for the block average pixelate tile averager.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import bap_pkg::*;

  typedef struct {
    bit [7:0]  red;
    bit [7:0]  green;
    bit [7:0]  blue;
    bit [10:0] col;
    bit [11:0] row;
    bit        done;
  } tile_avg_t;

  // Tile average predictor and store of expected tile results
  class tile_scoreboard;
    int unsigned width_reg, height_reg, block_reg;
    bit [19:0]   sum_red[MaxWidth];
    bit [19:0]   sum_green[MaxWidth];
    bit [19:0]   sum_blue[MaxWidth];
    int unsigned pix_col, pix_row, tcol, trow, tile_idx;
    tile_avg_t   pending_tiles[$];
    int          errors;

    function new();
      width_reg  = 640;
      height_reg = 480;
      block_reg  = 8;
      errors     = 0;
      restart();
    endfunction

    function void restart();
      pix_col  = 0;
      pix_row  = 0;
      tcol     = 0;
      trow     = 0;
      tile_idx = 0;
    endfunction

    function int unsigned clamp(int unsigned v, int unsigned hi);
      if (v < 1) return 1;
      if (v > hi) return hi;
      return v;
    endfunction

    function void set_reg(logic [3:0] addr, logic [31:0] value);
      case (addr[3:2])
        RegWidth:  width_reg  = value & 32'hFFF;
        RegHeight: height_reg = value & 32'h1FFF;
        RegBlock:  block_reg  = value & 32'h7F;
        default:   return;
      endcase
      restart();
    endfunction

    function logic [31:0] reg_value(logic [3:0] addr);
      case (addr[3:2])
        RegWidth:  return width_reg;
        RegHeight: return height_reg;
        RegBlock:  return block_reg;
        default:   return 0;
      endcase
    endfunction

    // Accumulate one accepted pixel and queue the tile result it finishes
    function void note_pixel(logic [23:0] pix);
      int unsigned w, h, b, t, x0, y0, tw, th, cnt;
      bit          last_col, last_row;
      tile_avg_t   res;
      w = clamp(width_reg, MaxWidth);
      h = clamp(height_reg, MaxHeight);
      b = clamp(block_reg, MaxBlock);
      t = tile_idx % MaxWidth;
      if (tcol == 0 && trow == 0) begin
        sum_red[t]   = 20'(pix[7:0]);
        sum_green[t] = 20'(pix[15:8]);
        sum_blue[t]  = 20'(pix[23:16]);
      end else begin
        sum_red[t]   = sum_red[t] + 20'(pix[7:0]);
        sum_green[t] = sum_green[t] + 20'(pix[15:8]);
        sum_blue[t]  = sum_blue[t] + 20'(pix[23:16]);
      end
      last_col = (pix_col + 1 >= w);
      last_row = (pix_row + 1 >= h);
      if ((last_col || tcol + 1 >= b) && (last_row || trow + 1 >= b)) begin
        x0  = pix_col - tcol;
        y0  = pix_row - trow;
        tw  = (w - x0 < b) ? w - x0 : b;
        th  = (h - y0 < b) ? h - y0 : b;
        cnt = tw * th;
        if (cnt == 0) cnt = 1;
        res.red   = 8'(sum_red[t] / cnt);
        res.green = 8'(sum_green[t] / cnt);
        res.blue  = 8'(sum_blue[t] / cnt);
        res.col   = 11'(tile_idx);
        res.row   = 12'(y0 / b);
        res.done  = last_col && last_row;
        pending_tiles.push_back(res);
      end
      // Advance the raster position
      if (last_col) begin
        pix_col  = 0;
        tcol     = 0;
        tile_idx = 0;
        if (last_row) begin
          pix_row = 0;
          trow    = 0;
        end else begin
          pix_row++;
          trow = (trow + 1 >= b) ? 0 : trow + 1;
        end
      end else begin
        pix_col++;
        if (tcol + 1 >= b) begin
          tcol = 0;
          tile_idx++;
        end else begin
          tcol++;
        end
      end
    endfunction

    function void report(string what, int unsigned got, int unsigned want);
      $display("mismatch at %0t: %s got %0d expected %0d", $time, what, got, want);
      errors++;
    endfunction

    // Compare one tile transfer with the oldest expected tile
    function void check_tile(logic [47:0] data);
      tile_avg_t e;
      if (pending_tiles.size() == 0) begin
        report("unexpected tile transfer", 1, 0);
        return;
      end
      e = pending_tiles.pop_front();
      if (data[7:0] !== e.red) report("avg_red", data[7:0], e.red);
      if (data[15:8] !== e.green) report("avg_green", data[15:8], e.green);
      if (data[23:16] !== e.blue) report("avg_blue", data[23:16], e.blue);
      if (data[34:24] !== e.col) report("tile_col", data[34:24], e.col);
      if (data[46:35] !== e.row) report("tile_row", data[46:35], e.row);
      if (data[47] !== e.done) report("frame_done", data[47], e.done);
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata = '0;   // red, green, blue
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  // avg_red, avg_green, avg_blue, tile_col, tile_row, frame_done
  logic [47:0] m_axis_tdata;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  tile_scoreboard tiles = new();
  bit          sink_quiet;
  bit          src_quiet;
  int unsigned idle_cycles = 0;
  int unsigned pixels_sent;

  block_average_pixelate_top u_top (.*);

  always #6 clk_i = ~clk_i;

  // Mostly short gaps, now and then a long one
  function automatic int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Note transfers on both streams and watch for a hang
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) tiles.note_pixel(s_axis_tdata);
      if (m_axis_tvalid && m_axis_tready) tiles.check_tile(m_axis_tdata);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || psel)
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles > 3000) begin
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  // Stall the receiver at random
  always begin
    int unsigned stall;
    m_axis_tready <= 1'b1;
    @(posedge clk_i);
    stall = sink_quiet ? 0 : gap_len();
    if (stall > 0) begin
      m_axis_tready <= 1'b0;
      repeat (stall) @(posedge clk_i);
    end
  end

  task automatic apb_write(logic [3:0] addr, logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    tiles.set_reg(addr, value);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    // Read back the register just written
    if (addr[3:2] inside {RegWidth, RegHeight, RegBlock}) begin
      @(posedge clk_i);
      psel <= 1'b1;
      @(posedge clk_i);
      penable <= 1'b1;
      @(posedge clk_i);
      while (!pready) @(posedge clk_i);
      if (prdata !== tiles.reg_value(addr))
        tiles.report("prdata", prdata, tiles.reg_value(addr));
      psel    <= 1'b0;
      penable <= 1'b0;
    end
    @(posedge clk_i);
  endtask

  task automatic send_pixel(logic [23:0] pix);
    int unsigned gap;
    gap = src_quiet ? 0 : gap_len();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= pix;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    pixels_sent++;
  endtask

  // Drop valid and wait until every expected tile has come out
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (tiles.pending_tiles.size() != 0) @(posedge clk_i);
    repeat (30) @(posedge clk_i);
  endtask

  task automatic configure(logic [31:0] w, logic [31:0] h, logic [31:0] b);
    apb_write(4'h0, w);
    apb_write(4'h4, h);
    apb_write(4'h8, b);
  endtask

  task automatic run_random(int unsigned n);
    repeat (n) send_pixel(24'($urandom()));
  endtask

  initial begin
    int unsigned w, h, b, n;
    pixels_sent = 0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset geometry: a few pixels, no tile finishes
    run_random(4);
    drain();

    // Zero registers act as one: every pixel is its own tile
    configure(32'h0001_0000, 32'hFFFF_E000, 32'h0000_0F80);
    send_pixel(24'h000000);
    send_pixel(24'hFFFFFF);
    send_pixel(24'h0000FF);
    send_pixel(24'h00FF00);
    send_pixel(24'hFF0000);
    send_pixel(24'h5AA55A);
    drain();

    // Oversized registers clamp to the maximum; unknown address is ignored
    configure(32'hFFF, 32'h1FFF, 32'h7F);
    apb_write(4'hC, 32'hFFFF_FFFF);
    run_random(5);
    drain();

    // Block larger than the image: one clipped tile per frame
    configure(5, 3, 100);
    repeat (15) send_pixel(24'hFFFFFF);
    drain();

    // Wide image with single-pixel tiles reaches high tile columns
    configure(1100, 1, 1);
    src_quiet = 1'b1;
    run_random(1100);
    src_quiet = 1'b0;
    drain();

    // Random geometries, mostly small, a few at the extremes
    while (pixels_sent < 1350) begin
      w = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 4095) : $urandom_range(1, 20);
      h = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 8191) : $urandom_range(1, 12);
      b = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 127) : $urandom_range(1, 6);
      configure(w, h, b);
      src_quiet  = ($urandom_range(0, 3) == 0);
      sink_quiet = ($urandom_range(0, 3) == 0);
      n = $urandom_range(20, 120);
      run_random(n);
      drain();
    end

    if (tiles.errors == 0 && tiles.pending_tiles.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

[filelist.f]
design/bap_pkg.sv
design/bap_ctrl.sv
design/bap_dpath.sv
design/block_average_pixelate_top.sv
design/bap_checker.sv
sim/tb_top.sv
